>>> rtl/core/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smeu_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned StackIdxW  = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned CodeDepth  = 4096;
  localparam int unsigned PcW        = $clog2(CodeDepth + 1);
  localparam int unsigned DivCntW    = $clog2(DataW + 1);

  // Opcodes as they appear in the code cell.
  localparam logic [DataW-1:0] OpPush  = DataW'(0);
  localparam logic [DataW-1:0] OpAdd   = DataW'(1);
  localparam logic [DataW-1:0] OpSub   = DataW'(2);
  localparam logic [DataW-1:0] OpMul   = DataW'(3);
  localparam logic [DataW-1:0] OpDiv   = DataW'(4);
  localparam logic [DataW-1:0] OpDup   = DataW'(5);
  localparam logic [DataW-1:0] OpCmpLt = DataW'(6);
  localparam logic [DataW-1:0] OpJmp   = DataW'(7);
  localparam logic [DataW-1:0] OpJz    = DataW'(8);
  localparam logic [DataW-1:0] OpHalt  = DataW'(9);

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_FAULT = 2'd2
  } run_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;     // take a request from the input channel
    logic start_div;  // launch the divider
    logic commit;     // write back stack, counters and status
    logic load_out;   // move the new state into the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;   // current instruction is a legal division
    logic div_done;   // quotient is ready
    logic out_free;   // result register can take a new result
  } ctrl_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/smeu_in_if.sv
// ----------------------------------------------------------------------------
// smeu_in_if
// Instruction request channel: opcode cell, next cell and its presence.
// ----------------------------------------------------------------------------
`default_nettype none

interface smeu_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [smeu_pkg::DataW-1:0] opcode;
  logic signed [smeu_pkg::DataW-1:0] operand;
  logic                           operand_present;

  modport source (output valid, output opcode, output operand,
                  output operand_present, input ready);
  modport sink   (input valid, input opcode, input operand,
                  input operand_present, output ready);
endinterface

`default_nettype wire

>>> rtl/core/smeu_out_if.sv
// ----------------------------------------------------------------------------
// smeu_out_if
// Result channel: next program counter, status, top value and stack depth.
// ----------------------------------------------------------------------------
`default_nettype none

interface smeu_out_if;
  logic                              valid;
  logic                              ready;
  logic [smeu_pkg::PcW-1:0]          next_pc;
  logic [1:0]                        status;
  logic signed [smeu_pkg::DataW-1:0] top_value;
  logic [smeu_pkg::CntW-1:0]         stack_depth;

  modport source (output valid, output next_pc, output status,
                  output top_value, output stack_depth, input ready);
  modport sink   (input valid, input next_pc, input status,
                  input top_value, input stack_depth, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack machine instruction per request.
// ----------------------------------------------------------------------------
// Each request on item_i carries the opcode cell at the current program
// counter, the following cell and whether that cell is inside the program.
// The unit holds the program counter, a 256-entry operand stack and the run
// status, executes the instruction and returns one result on result_o: the
// next program counter to fetch, the status (running, halted, fault), the
// top of stack on halt and the stack depth.
// After acceptance each instruction passes through the execute state, for
// div a wait state on the one-bit-per-cycle divider, and the done state
// that loads the result register; the unit takes one instruction at a time
// and accepts the next request only once that result has been loaded.
// The next request is accepted while an earlier result still waits in the
// result register; if the receiver stalls, the unit stops before loading
// the following result until that register frees up. program_length is
// written through cfg_we_i/cfg_wdata_i; the user must do so only while idle;
// the unit does not check. Reset clears the stack count, program counter and
// status and sets program_length to one; stack contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [smeu_pkg::PcW-1:0] cfg_wdata_i,
  smeu_in_if.sink                       item_i,
  smeu_out_if.source                    result_o
);

  smeu_pkg::ctrl_cmd_t  cmd;
  smeu_pkg::ctrl_stat_t stat;

  // The controller sequences each instruction through execute, an optional
  // divide wait and the hand-off to the result register.
  smeu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath owns the stack memory, machine state and result register.
  smeu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .item_i      (item_i),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/smeu_div.sv
// ----------------------------------------------------------------------------
// smeu_div
// Iterative signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [smeu_pkg::DataW-1:0] dividend_i,
  input  wire logic [smeu_pkg::DataW-1:0] divisor_i,
  output logic                            done_o,
  output logic [smeu_pkg::DataW-1:0]      quotient_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [smeu_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [smeu_pkg::DataW:0]           rem_q, rem_d;
  logic [smeu_pkg::DataW-1:0]         quo_q, quo_d;
  logic [smeu_pkg::DataW-1:0]         dvs_q, dvs_d;
  logic                               neg_q, neg_d;
  logic [smeu_pkg::DataW:0]           rem_sh;
  logic [smeu_pkg::DataW:0]           rem_sub;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    rem_sh  = {rem_q[smeu_pkg::DataW-1:0], quo_q[smeu_pkg::DataW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[smeu_pkg::DataW-1] ?
               (~dividend_i + smeu_pkg::DataW'(1)) : dividend_i;
      dvs_d  = divisor_i[smeu_pkg::DataW-1] ?
               (~divisor_i + smeu_pkg::DataW'(1)) : divisor_i;
      neg_d  = dividend_i[smeu_pkg::DataW-1] ^ divisor_i[smeu_pkg::DataW-1];
    end else if (busy_q) begin
      if (!rem_sub[smeu_pkg::DataW]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[smeu_pkg::DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[smeu_pkg::DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + smeu_pkg::DivCntW'(1);
      if (cnt_q == smeu_pkg::DivCntW'(smeu_pkg::DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + smeu_pkg::DataW'(1)) : quo_q;

endmodule

`default_nettype wire

>>> rtl/core/smeu_ctrl.sv
// ----------------------------------------------------------------------------
// smeu_ctrl
// Sequencer: accept, execute, optional divide wait, hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire smeu_pkg::ctrl_stat_t   stat_i,
  output smeu_pkg::ctrl_cmd_t         cmd_o
);

  smeu_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smeu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      smeu_pkg::S_IDLE: begin
        cmd_o.accept = 1'b1;
        if (in_valid_i) state_d = smeu_pkg::S_EXEC;
      end
      smeu_pkg::S_EXEC: begin
        if (stat_i.need_div) begin
          cmd_o.start_div = 1'b1;
          state_d = smeu_pkg::S_DIV;
        end else begin
          cmd_o.commit = 1'b1;
          state_d = smeu_pkg::S_DONE;
        end
      end
      smeu_pkg::S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d = smeu_pkg::S_DONE;
        end
      end
      smeu_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = smeu_pkg::S_IDLE;
        end
      end
      default: state_d = smeu_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/smeu_dp.sv
// ----------------------------------------------------------------------------
// smeu_dp
// Datapath: operand stack memory, machine state, execute logic, result.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [smeu_pkg::PcW-1:0]   cfg_wdata_i,
  input  wire smeu_pkg::ctrl_cmd_t        cmd_i,
  output smeu_pkg::ctrl_stat_t            stat_o,
  smeu_in_if.sink                         item_i,
  smeu_out_if.source                      result_o
);

  localparam int unsigned DW = smeu_pkg::DataW;
  localparam int unsigned IW = smeu_pkg::StackIdxW;
  localparam int unsigned CW = smeu_pkg::CntW;
  localparam int unsigned PW = smeu_pkg::PcW;

  logic [DW-1:0] mem [smeu_pkg::StackDepth];

  logic [PW-1:0] len_q;
  logic [PW-1:0] pc_q;
  logic [CW-1:0] cnt_q;
  smeu_pkg::run_status_e status_q;
  logic [DW-1:0] halt_top_q;
  logic [DW-1:0] op_q, opd_q;
  logic          pres_q;
  logic [DW-1:0] rd_top_q, rd_sec_q;

  logic          out_valid_q;
  logic [PW-1:0] out_pc_q;
  logic [1:0]    out_status_q;
  logic [DW-1:0] out_top_q;
  logic [CW-1:0] out_depth_q;

  logic [PW-1:0] len_eff;
  logic [IW-1:0] top_idx, sec_idx, cnt_idx;
  logic [PW-1:0] nx_pc;
  logic [CW-1:0] nx_cnt;
  smeu_pkg::run_status_e nx_status;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          fault, moved, is_halt, need_div;
  logic          tgt_bad;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [DW-1:0] prod;

  assign len_eff = (len_q > PW'(smeu_pkg::CodeDepth)) ? PW'(smeu_pkg::CodeDepth) : len_q;
  assign cnt_idx = cnt_q[IW-1:0];
  assign top_idx = cnt_idx - IW'(1);
  assign sec_idx = cnt_idx - IW'(2);
  assign prod    = rd_sec_q * rd_top_q;
  assign tgt_bad = opd_q[DW-1] || (opd_q[DW-2:PW] != '0) || (opd_q[PW-1:0] >= len_eff);

  // Execute decision for the latched instruction.
  always_comb begin
    nx_pc     = pc_q;
    nx_cnt    = cnt_q;
    nx_status = status_q;
    wr_en     = 1'b0;
    wr_addr   = sec_idx;
    wr_data   = '0;
    fault     = 1'b0;
    moved     = 1'b0;
    is_halt   = 1'b0;
    need_div  = 1'b0;
    if (status_q != smeu_pkg::ST_RUN) begin
      // Finished machine: nothing changes.
    end else if (pc_q >= len_eff) begin
      fault = 1'b1;
    end else begin
      unique case (op_q)
        smeu_pkg::OpPush: begin
          if (!pres_q || cnt_q >= CW'(smeu_pkg::StackDepth)) fault = 1'b1;
          else begin
            wr_en   = 1'b1;
            wr_addr = cnt_idx;
            wr_data = opd_q;
            nx_cnt  = cnt_q + CW'(1);
            nx_pc   = pc_q + PW'(2);
            moved   = 1'b1;
          end
        end
        smeu_pkg::OpAdd, smeu_pkg::OpSub, smeu_pkg::OpMul,
        smeu_pkg::OpDiv, smeu_pkg::OpCmpLt: begin
          if (cnt_q < CW'(2)) fault = 1'b1;
          else if (op_q == smeu_pkg::OpDiv && rd_top_q == '0) fault = 1'b1;
          else begin
            wr_en   = 1'b1;
            wr_addr = sec_idx;
            if (op_q == smeu_pkg::OpAdd)      wr_data = rd_sec_q + rd_top_q;
            else if (op_q == smeu_pkg::OpSub) wr_data = rd_sec_q - rd_top_q;
            else if (op_q == smeu_pkg::OpMul) wr_data = prod;
            else if (op_q == smeu_pkg::OpDiv) wr_data = div_q;
            else wr_data = DW'($signed(rd_sec_q) < $signed(rd_top_q));
            need_div = (op_q == smeu_pkg::OpDiv);
            nx_cnt   = cnt_q - CW'(1);
            nx_pc    = pc_q + PW'(1);
            moved    = 1'b1;
          end
        end
        smeu_pkg::OpDup: begin
          if (cnt_q == '0 || cnt_q >= CW'(smeu_pkg::StackDepth)) fault = 1'b1;
          else begin
            wr_en   = 1'b1;
            wr_addr = cnt_idx;
            wr_data = rd_top_q;
            nx_cnt  = cnt_q + CW'(1);
            nx_pc   = pc_q + PW'(1);
            moved   = 1'b1;
          end
        end
        smeu_pkg::OpJmp: begin
          if (!pres_q || tgt_bad) fault = 1'b1;
          else begin
            nx_pc = opd_q[PW-1:0];
            moved = 1'b1;
          end
        end
        smeu_pkg::OpJz: begin
          if (!pres_q || cnt_q == '0) fault = 1'b1;
          else if (rd_top_q == '0) begin
            if (tgt_bad) fault = 1'b1;
            else begin
              nx_pc  = opd_q[PW-1:0];
              nx_cnt = cnt_q - CW'(1);
              moved  = 1'b1;
            end
          end else begin
            nx_pc  = pc_q + PW'(2);
            nx_cnt = cnt_q - CW'(1);
            moved  = 1'b1;
          end
        end
        smeu_pkg::OpHalt: begin
          is_halt   = 1'b1;
          nx_status = smeu_pkg::ST_HALT;
        end
        default: fault = 1'b1;
      endcase
    end
    if (fault) begin
      nx_pc     = pc_q;
      nx_cnt    = cnt_q;
      wr_en     = 1'b0;
      need_div  = 1'b0;
      nx_status = smeu_pkg::ST_FAULT;
    end else if (moved && nx_pc >= len_eff) begin
      nx_status = smeu_pkg::ST_FAULT;
    end
  end

  smeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (rd_sec_q),
    .divisor_i  (rd_top_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Stack memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) mem[wr_addr] <= wr_data;
    rd_top_q <= mem[top_idx];
    rd_sec_q <= mem[sec_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= PW'(1);
      pc_q        <= '0;
      cnt_q       <= '0;
      status_q    <= smeu_pkg::ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) len_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        pc_q     <= nx_pc;
        cnt_q    <= nx_cnt;
        status_q <= nx_status;
      end
      if (cmd_i.load_out)    out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && item_i.valid) begin
      op_q   <= item_i.opcode;
      opd_q  <= item_i.operand;
      pres_q <= item_i.operand_present;
    end
    if (cmd_i.commit && is_halt) halt_top_q <= (cnt_q == '0) ? '0 : rd_top_q;
    if (cmd_i.load_out) begin
      out_pc_q     <= pc_q;
      out_status_q <= status_q;
      out_top_q    <= (status_q == smeu_pkg::ST_HALT) ? halt_top_q : '0;
      out_depth_q  <= cnt_q;
    end
  end

  assign item_i.ready         = cmd_i.accept;
  assign result_o.valid       = out_valid_q;
  assign result_o.next_pc     = out_pc_q;
  assign result_o.status      = out_status_q;
  assign result_o.top_value   = out_top_q;
  assign result_o.stack_depth = out_depth_q;

  assign stat_o.need_div = need_div;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || result_o.ready;

  // The stack count never passes the stack size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(smeu_pkg::StackDepth))
    else $error("stack count beyond stack size");

  // A halted or faulted machine stays so until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != smeu_pkg::ST_RUN |=> status_q == $past(status_q))
    else $error("run status left a final state");

  // A result reports the state left by the committed instruction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_depth_q == $past(cnt_q) && out_pc_q == $past(pc_q))
    else $error("result does not match machine state");

endmodule

`default_nettype wire

>>> tb/tb_stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_stack_machine_execute_unit
// Self-checking testbench of the stack machine execute unit.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the program counter, the operand
// stack, the run status and program_length. It works out the result of
// every accepted request and compares each accepted result field by field.
// The stimulus is built from the predicted state so that long programs keep
// running. The random part walks the stack depth between empty and full and
// takes jumps across the whole program. Since only one reset is allowed,
// the run ends with one terminating instruction, either a halt or one kind
// of fault, followed by requests that the unit must ignore.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stack_machine_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import smeu_pkg::*;

  typedef logic [DataW-1:0] word_t;
  typedef logic [PcW-1:0]   pc_t;
  typedef logic [CntW-1:0]  depth_t;

  typedef struct {
    pc_t         next_pc;
    run_status_e status;
    word_t       top_value;
    depth_t      stack_depth;
  } exec_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: instruction predictor plus the queue of expected results.
  // --------------------------------------------------------------------------
  class exec_scoreboard;
    word_t        stk[StackDepth];
    int unsigned  depth;
    int unsigned  pc;
    run_status_e  status;
    int unsigned  prog_len;
    exec_result_t expected_q[$];
    int unsigned  errors;

    function new();
      depth    = 0;
      pc       = 0;
      status   = ST_RUN;
      prog_len = 1;
      errors   = 0;
    endfunction

    function int unsigned eff_len();
      return (prog_len > CodeDepth) ? CodeDepth : prog_len;
    endfunction

    function word_t top_word();
      return (depth == 0) ? '0 : stk[depth-1];
    endfunction

    // Signed 32-bit division that truncates toward zero; INT_MIN / -1 wraps.
    function word_t div_trunc(word_t a, word_t b);
      word_t ma;
      word_t mb;
      word_t q;
      ma = a[DataW-1] ? -a : a;
      mb = b[DataW-1] ? -b : b;
      q  = ma / mb;
      return (a[DataW-1] != b[DataW-1]) ? -q : q;
    endfunction

    function void push_expected();
      exec_result_t r;
      r.next_pc     = pc_t'(pc);
      r.status      = status;
      r.top_value   = (status == ST_HALT) ? top_word() : '0;
      r.stack_depth = depth_t'(depth);
      expected_q.push_back(r);
    endfunction

    // Executes one accepted instruction request.
    function void note_request(word_t op, word_t opd, logic present);
      int unsigned len;
      int unsigned n;
      int unsigned npc;
      word_t       a;
      word_t       b;
      word_t       r;
      logic        fault;
      len   = eff_len();
      n     = depth;
      npc   = pc;
      fault = 1'b0;
      if (status != ST_RUN) begin
        push_expected();
        return;
      end
      if (pc >= len) begin
        status = ST_FAULT;
        push_expected();
        return;
      end
      case (op)
        OpPush: begin
          if (!present || n >= StackDepth) begin
            fault = 1'b1;
          end else begin
            stk[n] = opd;
            n++;
            npc += 2;
          end
        end
        OpAdd, OpSub, OpMul, OpDiv, OpCmpLt: begin
          if (n < 2) begin
            fault = 1'b1;
          end else begin
            a = stk[n-2];
            b = stk[n-1];
            r = '0;
            case (op)
              OpAdd: r = a + b;
              OpSub: r = a - b;
              OpMul: r = a * b;
              OpDiv: begin
                if (b == '0) fault = 1'b1;
                else r = div_trunc(a, b);
              end
              default: r = ($signed(a) < $signed(b)) ? word_t'(1) : '0;
            endcase
            if (!fault) begin
              stk[n-2] = r;
              n--;
              npc += 1;
            end
          end
        end
        OpDup: begin
          if (n < 1 || n >= StackDepth) begin
            fault = 1'b1;
          end else begin
            stk[n] = stk[n-1];
            n++;
            npc += 1;
          end
        end
        OpJmp: begin
          if (!present || opd[DataW-1] || opd >= len) fault = 1'b1;
          else npc = opd;
        end
        OpJz: begin
          if (!present || n < 1) begin
            fault = 1'b1;
          end else if (stk[n-1] == '0) begin
            if (opd[DataW-1] || opd >= len) fault = 1'b1;
            else npc = opd;
          end else begin
            npc += 2;
          end
          if (!fault) n--;
        end
        OpHalt: begin
          status = ST_HALT;
          push_expected();
          return;
        end
        default: fault = 1'b1;
      endcase
      if (fault) begin
        status = ST_FAULT;
      end else begin
        depth = n;
        pc    = npc;
        if (pc >= len) status = ST_FAULT;
      end
      push_expected();
    endfunction

    function void check_result(pc_t next_pc, logic [1:0] st, word_t top, depth_t dep);
      exec_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no pending instruction: next_pc=%0d status=%0d", next_pc, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (next_pc !== e.next_pc) begin
        $error("next_pc: expected %0d, actual %0d", e.next_pc, next_pc);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (top !== e.top_value) begin
        $error("top_value: expected %h, actual %h", e.top_value, top);
        errors++;
      end
      if (dep !== e.stack_depth) begin
        $error("stack_depth: expected %0d, actual %0d", e.stack_depth, dep);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block under test.
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  pc_t  cfg_wdata_i;

  smeu_in_if  item_if ();
  smeu_out_if result_if ();

  stack_machine_execute_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if.sink),
    .result_o   (result_if.source)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  exec_scoreboard sb = new();

  // When set, neither side idles, so back-to-back traffic is covered too.
  logic        no_idle;
  int unsigned accept_count;   // accepted requests and results, for the watchdog
  int unsigned target_depth;   // stack depth the random walk heads for

  // --------------------------------------------------------------------------
  // Result side: random stalls, sampling at the falling edge so the check
  // does not race the block's own updates at the rising edge.
  // --------------------------------------------------------------------------
  initial begin
    logic        take;
    pc_t         s_pc;
    logic [1:0]  s_st;
    word_t       s_top;
    depth_t      s_dep;
    int unsigned stall;
    stall = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      take = rst_ni && result_if.valid && result_if.ready;
      s_pc  = result_if.next_pc;
      s_st  = result_if.status;
      s_top = result_if.top_value;
      s_dep = result_if.stack_depth;
      @(posedge clk_i);
      if (take) begin
        sb.check_result(s_pc, s_st, s_top, s_dep);
        accept_count++;
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        stall--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if nothing is accepted for too long.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    int unsigned last;
    quiet = 0;
    last  = 0;
    forever begin
      @(posedge clk_i);
      if (accept_count != last) begin
        last  = accept_count;
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= 2000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Presents one request after a random gap and returns at the edge that
  // accepts it. valid stays high on return; the next call lowers it only if
  // it draws a gap, so valid never gets two assignments in one step.
  task automatic send_request(word_t op, word_t opd, logic present);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid           <= 1'b1;
    item_if.opcode          <= op;
    item_if.operand         <= opd;
    item_if.operand_present <= present;
    forever begin
      @(negedge clk_i);
      if (item_if.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sb.note_request(op, opd, present);
    accept_count++;
  endtask

  // Waits until every expected result has arrived and the unit has settled.
  task automatic wait_idle();
    if (item_if.valid) item_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_length(pc_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.prog_len = value;
  endtask

  // Operand values lean toward the corners of the 32-bit range.
  function automatic word_t rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      4: return word_t'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Sends one instruction that keeps the machine running, chosen from the
  // predicted state. The stack depth drifts toward target_depth.
  task automatic send_legal();
    int unsigned len;
    int unsigned n;
    int unsigned pick;
    logic        room1;
    logic        room2;
    logic        grow;
    word_t       tgt;
    len   = sb.eff_len();
    n     = sb.depth;
    room1 = (sb.pc + 1 < len);
    room2 = (sb.pc + 2 < len);
    tgt   = word_t'($urandom_range(0, len - 1));
    grow  = (n < target_depth);
    pick  = $urandom_range(0, 99);
    if (pick < 8) begin
      send_request(OpJmp, tgt, 1'b1);
    end else if (grow && pick < 70 && room2 && n < StackDepth) begin
      send_request(OpPush, rand_value(), 1'b1);
    end else if (grow && room1 && n >= 1 && n < StackDepth) begin
      send_request(OpDup, $urandom(), 1'($urandom()));
    end else if (!grow && n >= 2 && room1) begin
      case ($urandom_range(0, 5))
        0: send_request(OpAdd, $urandom(), 1'($urandom()));
        1: send_request(OpSub, $urandom(), 1'($urandom()));
        2: send_request(OpMul, $urandom(), 1'($urandom()));
        3: send_request(OpCmpLt, $urandom(), 1'($urandom()));
        default: begin
          if (sb.top_word() != '0) send_request(OpDiv, $urandom(), 1'($urandom()));
          else send_request(OpJz, tgt, 1'b1);
        end
      endcase
    end else if (!grow && n >= 1 && (sb.top_word() == '0 || room2)) begin
      send_request(OpJz, tgt, 1'b1);
    end else if (room2 && n < StackDepth) begin
      send_request(OpPush, rand_value(), 1'b1);
    end else begin
      send_request(OpJmp, tgt, 1'b1);
    end
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 4))
          0: target_depth = StackDepth;
          1: target_depth = 0;
          default: target_depth = $urandom_range(0, 8);
        endcase
      end
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_legal();
    end
  endtask

  // Ends the program with a halt or with one kind of fault.
  task automatic send_terminal();
    word_t op;
    int unsigned len;
    len = sb.eff_len();
    case ($urandom_range(0, 7))
      0: send_request(OpHalt, $urandom(), 1'($urandom()));
      1: begin
        // Unknown opcode.
        do op = $urandom(); while (op <= OpHalt);
        send_request(op, $urandom(), 1'($urandom()));
      end
      2: send_request(OpPush, $urandom(), 1'b0);        // missing operand
      3: send_request(OpJmp, 32'h8000_0000 | $urandom(), 1'b1);  // negative target
      4: send_request(OpJmp, word_t'(len), 1'b1);       // target at program end
      5: begin
        // Division by zero, or underflow when the stack is too shallow.
        if (sb.depth < StackDepth && sb.pc + 2 < len) send_request(OpPush, '0, 1'b1);
        send_request(OpDiv, $urandom(), 1'($urandom()));
      end
      6: begin
        // Running past the end: the last cell holds a push.
        send_request(OpJmp, word_t'(len - 1), 1'b1);
        send_request(OpPush, $urandom(), 1'b1);
      end
      default: begin
        // Underflow on an empty stack, or halt with the stack as it is.
        if (sb.depth == 0) send_request(OpAdd, $urandom(), 1'b1);
        else send_request(OpHalt, '0, 1'b0);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    accept_count            = 0;
    no_idle                 = 1'b0;
    target_depth            = 4;
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_wdata_i             = '0;
    item_if.valid           = 1'b0;
    item_if.opcode          = '0;
    item_if.operand         = '0;
    item_if.operand_present = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-cell program: only a jump to cell zero keeps it running.
    write_length(pc_t'(1));
    repeat (4) send_request(OpJmp, '0, 1'b1);
    wait_idle();

    // Oversized length acts as the full code depth. Directed arithmetic
    // corners: wraparound, INT_MIN / -1, truncation, compare, jz both ways.
    write_length(pc_t'(8191));
    send_request(OpPush, 32'h7fff_ffff, 1'b1);
    send_request(OpPush, 32'h8000_0000, 1'b1);
    send_request(OpAdd, '1, 1'b0);
    send_request(OpPush, '1, 1'b1);
    send_request(OpSub, '0, 1'b1);
    send_request(OpPush, 32'h8000_0000, 1'b1);
    send_request(OpPush, '1, 1'b1);
    send_request(OpDiv, '0, 1'b0);
    send_request(OpDup, '1, 1'b1);
    send_request(OpMul, '0, 1'b0);
    send_request(OpPush, 32'd7, 1'b1);
    send_request(OpPush, -32'sd3, 1'b1);
    send_request(OpDiv, '0, 1'b1);
    send_request(OpCmpLt, '1, 1'b0);
    send_request(OpJz, 32'd4095, 1'b1);
    send_request(OpJmp, 32'd100, 1'b1);
    send_request(OpPush, 32'd5, 1'b1);
    send_request(OpJz, '0, 1'b1);
    send_request(OpJmp, '0, 1'b1);
    wait_idle();

    write_length(pc_t'(CodeDepth));
    run_random(500);
    send_request(OpJmp, '0, 1'b1);
    wait_idle();

    // Short programs force frequent jumps near the end.
    write_length(pc_t'($urandom_range(3, 40)));
    run_random(550);
    no_idle = 1'b0;
    send_terminal();

    // The unit is stopped now; everything after must be ignored.
    repeat (20) send_request($urandom(), $urandom(), 1'($urandom()));
    wait_idle();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
